### sv/mtpu_pkg.sv
// Shared constants, types and helpers of the point-update mex tracker.
package mtpu_pkg;

    localparam int POSITIONS  = 1024;
    localparam int VALUE_BITS = 32;

    localparam int POS_W    = 10;
    localparam int NEWV_W   = 32;
    localparam int MEX_W    = 11;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam int CNT_W      = $clog2(POSITIONS + 1);
    localparam int IDX_W      = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int ROW_BITS   = 32;
    localparam int ROW_W      = $clog2(ROW_BITS);
    localparam int ROWS       = (POSITIONS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWS_PAD   = 1 << ROW_IDX_W;
    localparam int VIDX_W     = ROW_W + ROW_IDX_W;
    localparam int CNT_DEPTH  = 1 << VIDX_W;

    typedef struct packed {
        logic clr;
        logic cap;
        logic ent_wr;
        logic ld_old;
        logic ld_new;
        logic u_rd;
        logic u_wr;
        logic dec;
        logic find_rd;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pos_ok;
        logic old_cnt;
        logic new_ok;
    } t_sts;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] idx;
    } t_ffz;

    function automatic logic in_range(input logic [VALUE_BITS-1:0] v);
        return 64'(v) < 64'(POSITIONS);
    endfunction

    function automatic t_ffz first_zero(input logic [ROW_BITS-1:0] row);
        t_ffz res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!row[i]) begin
                res.found = 1'b1;
                res.idx   = ROW_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### sv/mtpu_ctrl.sv
// Sequencer: clearing pass, count read-modify-write steps, mex search, output beat.
module mtpu_ctrl
    import mtpu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic i_m_tready,
    output logic o_m_tvalid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ENT, S_ORD, S_OWR, S_NLD, S_NRD, S_NWR, S_FRD, S_FWR
    } t_state;

    t_state r_state, n_state;
    logic   r_tvalid;
    logic   w_out_free;

    assign w_out_free = !r_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_ENT;
                end
            end
            S_ENT: begin
                o_cmd.ld_old = 1'b1;
                if (!i_sts.pos_ok) begin
                    n_state = S_FRD;
                end else begin
                    o_cmd.ent_wr = 1'b1;
                    n_state      = i_sts.old_cnt ? S_ORD : S_NLD;
                end
            end
            S_ORD: begin
                o_cmd.u_rd = 1'b1;
                n_state    = S_OWR;
            end
            S_OWR: begin
                o_cmd.u_wr = 1'b1;
                o_cmd.dec  = 1'b1;
                n_state    = S_NLD;
            end
            S_NLD: begin
                o_cmd.ld_new = 1'b1;
                n_state      = i_sts.new_ok ? S_NRD : S_FRD;
            end
            S_NRD: begin
                o_cmd.u_rd = 1'b1;
                n_state    = S_NWR;
            end
            S_NWR: begin
                o_cmd.u_wr = 1'b1;
                n_state    = S_FRD;
            end
            S_FRD: begin
                o_cmd.find_rd = 1'b1;
                n_state       = S_FWR;
            end
            S_FWR: begin
                if (w_out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_ld) begin
                r_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

endmodule

### sv/mtpu_dpath.sv
// Datapath: entry store, value counts, presence bitmap with row-full summary, mex search.
module mtpu_dpath
    import mtpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [POS_W-1:0] i_pos,
    input  logic [NEWV_W-1:0] i_new_value,
    output logic [MEX_W-1:0] o_mex
);

    logic [VALUE_BITS:0]   r_ent_mem [POSITIONS];
    logic [CNT_W-1:0]      r_cnt_mem [CNT_DEPTH];
    logic [ROW_BITS-1:0]   r_bmp_mem [ROWS_PAD];

    logic [VALUE_BITS:0]   r_ent;
    logic [CNT_W-1:0]      r_cnt;
    logic [ROW_BITS-1:0]   r_row;
    logic [ROWS_PAD-1:0]   r_full;
    logic [VIDX_W-1:0]     r_clr;
    logic [VIDX_W-1:0]     r_vidx;
    logic [POS_W-1:0]      r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic [ROW_IDX_W-1:0]  r_find_row;
    logic                  r_find_none;
    logic [MEX_W-1:0]      r_mex;

    logic [ROW_IDX_W-1:0]  w_vrow;
    logic [ROW_W-1:0]      w_vbit;
    logic [CNT_W-1:0]      w_cnt_new;
    logic [ROW_BITS-1:0]   w_row_new;
    logic [ROW_IDX_W-1:0]  w_sum_row;
    logic                  w_sum_none;
    t_ffz                  w_ffz;
    logic [VIDX_W:0]       w_mex;
    logic                  w_clr_ent;
    logic                  w_ent_we;
    logic [IDX_W-1:0]      w_ent_wa;
    logic [VALUE_BITS:0]   w_ent_wd;
    logic [ROW_IDX_W-1:0]  w_bmp_ra;

    assign w_vrow = r_vidx[VIDX_W-1:ROW_W];
    assign w_vbit = r_vidx[ROW_W-1:0];

    always_comb begin
        if (i_cmd.dec) begin
            w_cnt_new = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;
        end else begin
            w_cnt_new = (r_cnt < CNT_W'(POSITIONS)) ? r_cnt + 1'b1 : r_cnt;
        end
        w_row_new         = r_row;
        w_row_new[w_vbit] = (w_cnt_new != '0);
    end

    always_comb begin
        w_sum_none = 1'b1;
        w_sum_row  = '0;
        for (int i = ROWS_PAD - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                w_sum_none = 1'b0;
                w_sum_row  = ROW_IDX_W'(i);
            end
        end
    end

    assign w_ffz = first_zero(r_row);
    assign w_mex = r_find_none ? (VIDX_W + 1)'(CNT_DEPTH) : {1'b0, r_find_row, w_ffz.idx};

    assign w_clr_ent = (32'(r_clr) < 32'(POSITIONS));
    assign w_ent_we  = (i_cmd.clr && w_clr_ent) || i_cmd.ent_wr;
    assign w_ent_wa  = i_cmd.clr ? IDX_W'(r_clr) : IDX_W'(r_pos);
    assign w_ent_wd  = i_cmd.clr ? '0 : {1'b1, r_val};
    assign w_bmp_ra  = i_cmd.find_rd ? w_sum_row : w_vrow;

    assign o_sts.clr_last = (r_clr == '1);
    assign o_sts.pos_ok   = (32'(r_pos) < 32'(POSITIONS));
    assign o_sts.old_cnt  = r_ent[VALUE_BITS] && in_range(r_ent[VALUE_BITS-1:0]);
    assign o_sts.new_ok   = in_range(r_val);
    assign o_mex          = r_mex;

    // entry store
    always_ff @(posedge i_clk) begin
        if (w_ent_we) r_ent_mem[w_ent_wa] <= w_ent_wd;
        if (i_cmd.cap) r_ent <= r_ent_mem[IDX_W'(i_pos)];
    end

    // value counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_cnt_mem[r_clr] <= '0;
        end else if (i_cmd.u_wr) begin
            r_cnt_mem[r_vidx] <= w_cnt_new;
        end
        if (i_cmd.u_rd) r_cnt <= r_cnt_mem[r_vidx];
    end

    // presence bitmap, one row per 32 values
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_bmp_mem[r_clr[ROW_IDX_W-1:0]] <= '0;
        end else if (i_cmd.u_wr) begin
            r_bmp_mem[w_vrow] <= w_row_new;
        end
        if (i_cmd.u_rd || i_cmd.find_rd) r_row <= r_bmp_mem[w_bmp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_full <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.u_wr) r_full[w_vrow] <= &w_row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pos <= i_pos;
            r_val <= VALUE_BITS'(i_new_value);
        end
        if (i_cmd.ld_old) begin
            r_vidx <= VIDX_W'(r_ent[VALUE_BITS-1:0]);
        end else if (i_cmd.ld_new) begin
            r_vidx <= VIDX_W'(r_val);
        end
        if (i_cmd.find_rd) begin
            r_find_row  <= w_sum_row;
            r_find_none <= w_sum_none;
        end
        if (i_cmd.out_ld) r_mex <= MEX_W'(w_mex);
    end

endmodule

### sv/mex_tracker_point_update.sv
// Top level: mex of an array under point writes, stream in and out.
// Each input beat runs up to two count read-modify-writes, then a two-level first-zero
// search over the row-full summary and one bitmap row, before its output beat.
// Items are taken one at a time: s_axis_tready is high only while idle between items.
// Reset: synchronous, active low; a clearing pass then zeros all counts,
// occupied marks and bitmap rows, with s_axis_tready low until it ends.
module mex_tracker_point_update
    import mtpu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [9:0] position, [41:10] new_value
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata    // [10:0] mex
);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [MEX_W-1:0] w_mex;

    mtpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtpu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pos       (s_axis_tdata[POS_W-1:0]),
        .i_new_value (s_axis_tdata[POS_W+NEWV_W-1:POS_W]),
        .o_mex       (w_mex)
    );

    assign m_axis_tdata = {{(M_DATA_W - MEX_W){1'b0}}, w_mex};

endmodule
